>>> src/keyboard_scancode_fifo_macros.svh
// assertion helpers included by keyboard_scancode_fifo.sv
`ifndef KEYBOARD_SCANCODE_FIFO_MACROS_SVH
`define KEYBOARD_SCANCODE_FIFO_MACROS_SVH

// same-cycle implication, checked out of reset
`define KSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kbsc_pkg.sv
package kbsc_pkg;

  localparam logic       ACT_BYTE    = 1'b0;
  localparam logic       ACT_READ    = 1'b1;
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] PREFIX_HIGH = 8'hE0;  // upper byte of a prefixed 0xE0xx code

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
  } in_t;

  typedef struct packed {
    logic        buffer_empty;
    logic [15:0] key_code;
  } out_t;

  // stored code: prefix flag and raw byte
  typedef struct packed {
    logic       prefix;
    logic [7:0] code_byte;
  } entry_t;

  typedef struct packed {
    logic load_new;
    logic shift;
  } cell_ctl_t;

endpackage

>>> src/kbsc_cell.sv
module kbsc_cell (
  input  logic                clk_i,
  input  kbsc_pkg::cell_ctl_t ctl_i,
  input  kbsc_pkg::entry_t    new_entry_i,
  input  kbsc_pkg::entry_t    next_entry_i,
  output kbsc_pkg::entry_t    entry_o
);

  kbsc_pkg::entry_t entry_d, entry_q;

  // a pop moves the whole row one cell toward the head
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = next_entry_i;
    end else if (ctl_i.load_new) begin
      entry_d = new_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> src/keyboard_scancode_fifo.sv
// a read result is registered and shows in the cycle after its transfer
// throughput: one item per cycle while the output side takes results
// storage is a row of DEPTH-1 cells; the head cell always holds the oldest code
// reset: occupancy count, prefix flag and output valid clear asynchronously;
// cell contents are left as they are and never read before being written
module keyboard_scancode_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kbsc_pkg::in_t  in_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output kbsc_pkg::out_t out_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  `include "keyboard_scancode_fifo_macros.svh"

  localparam int unsigned NumCells = DEPTH - 1;   // capacity is one less than DEPTH
  localparam int unsigned CntW     = $clog2(DEPTH);

  // handshake and decode
  logic in_fire, is_read, store_req, full, push, pop;

  // occupancy count stands in for write minus read index
  logic [CntW-1:0] count_d, count_q;
  logic            prefix_d, prefix_q;

  logic            out_valid_d, out_valid_q;
  kbsc_pkg::out_t  out_d, out_q;

  kbsc_pkg::entry_t new_entry;
  kbsc_pkg::entry_t entries [NumCells];

  // next item is taken whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_read    = (in_i.action == kbsc_pkg::ACT_READ);

  // a lone prefix byte only arms the flag; anything else is a code to store
  assign store_req = in_fire && !is_read &&
                     (prefix_q || (in_i.scan_byte != kbsc_pkg::PREFIX_BYTE));
  assign full      = (count_q == CntW'(NumCells));
  assign push      = store_req && !full;           // full buffer drops silently
  assign pop       = in_fire && is_read && (count_q != '0);

  assign new_entry = '{prefix: prefix_q, code_byte: in_i.scan_byte};

  always_comb begin
    count_d = count_q;
    if (push) begin
      count_d = count_q + CntW'(1);
    end else if (pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // any byte transfer consumes a pending prefix, even if its code is dropped
  always_comb begin
    prefix_d = prefix_q;
    if (in_fire && !is_read) begin
      prefix_d = !prefix_q && (in_i.scan_byte == kbsc_pkg::PREFIX_BYTE);
    end
  end

  // the cell row: new code lands in the first free cell, pop shifts all
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    kbsc_pkg::cell_ctl_t ctl;
    kbsc_pkg::entry_t    next_entry;

    assign ctl.load_new = push && (count_q == CntW'(i));
    assign ctl.shift    = pop;

    if (i == NumCells - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = entries[i+1];
    end

    kbsc_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_entry_i  (new_entry),
      .next_entry_i (next_entry),
      .entry_o      (entries[i])
    );
  end

  // result register: a read on an empty buffer reports empty with a zero code
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_fire && is_read) begin
      out_valid_d = 1'b1;
      if (count_q == '0) begin
        out_d.buffer_empty = 1'b1;
        out_d.key_code     = '0;
      end else begin
        out_d.buffer_empty = 1'b0;
        out_d.key_code     = {(entries[0].prefix ? kbsc_pkg::PREFIX_HIGH : 8'h00),
                              entries[0].code_byte};
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      prefix_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      prefix_q    <= prefix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  // occupancy never passes the usable capacity
  `KSF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(NumCells), "count over capacity")
  // a stored code that fits grows the count by one
  `KSF_ASSERT_NEXT(a_push_grows, store_req && !full, count_q == $past(count_q) + CntW'(1), "push lost")
  // a read on a nonempty buffer shrinks the count by one
  `KSF_ASSERT_NEXT(a_pop_shrinks, pop, count_q == $past(count_q) - CntW'(1), "pop lost")
  // a read on an empty buffer yields an empty result with zero code
  `KSF_ASSERT_NEXT(a_empty_read, in_fire && is_read && (count_q == '0), out_valid_o && out_o.buffer_empty && (out_o.key_code == 16'h0000), "bad empty read")
  // push and pop never coincide
  `KSF_ASSERT_NOW(a_one_op, push, !pop, "push and pop together")

endmodule

>>> tb/sv/keyboard_scancode_fifo_tb.sv
module keyboard_scancode_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIFO_DEPTH    = 16;
  // capacity is one less than the depth
  localparam int unsigned FIFO_CAPACITY = FIFO_DEPTH - 1;
  localparam int unsigned MAX_WAIT      = 15;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 200_000;

  // dut inputs, all driven to known values from time zero
  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  kbsc_pkg::in_t  in_i        = '0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  kbsc_pkg::out_t out_o;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;

  // scoreboard state
  kbsc_pkg::entry_t buffered_codes[$];   // codes the block should be holding
  logic             prefix_pending = 1'b0;
  kbsc_pkg::out_t   expected_pops[$];    // read results still to come
  kbsc_pkg::out_t   oldest_pop;
  int unsigned      mismatches  = 0;
  int unsigned      items_sent  = 0;
  bit               quiet       = 1'b0;  // no idling on either side while set
  longint unsigned  cycle_count = 0;

  keyboard_scancode_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyboard_scancode_fifo regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction: prefix decoding plus a bounded fifo of stored codes
  // ---------------------------------------------------------------------------

  // store a code unless the buffer is full, in which case it is lost
  function automatic void store_code(kbsc_pkg::entry_t code);
    if (buffered_codes.size() < FIFO_CAPACITY) buffered_codes.push_back(code);
  endfunction

  // update the model for one accepted transfer, queue the read result if any
  function automatic void predict_key_code(kbsc_pkg::in_t item);
    kbsc_pkg::entry_t code;
    kbsc_pkg::out_t   res;
    if (item.action == kbsc_pkg::ACT_BYTE) begin
      if (prefix_pending) begin
        // byte after a prefix is stored flagged, even another prefix byte
        prefix_pending = 1'b0;
        store_code('{prefix: 1'b1, code_byte: item.scan_byte});
      end else if (item.scan_byte == kbsc_pkg::PREFIX_BYTE) begin
        prefix_pending = 1'b1;
      end else begin
        store_code('{prefix: 1'b0, code_byte: item.scan_byte});
      end
    end else begin
      // reads leave the prefix flag alone
      if (buffered_codes.size() == 0) begin
        res.buffer_empty = 1'b1;
        res.key_code     = '0;
      end else begin
        code             = buffered_codes.pop_front();
        res.buffer_empty = 1'b0;
        res.key_code     = {code.prefix ? kbsc_pkg::PREFIX_HIGH : 8'h00, code.code_byte};
      end
      expected_pops.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls on out_ready_i, field by field checking
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // hold ready until one result transfer completes
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pops.size() == 0) begin
        $error("result with nothing expected: buffer_empty %0d key_code 0x%04h",
               out_o.buffer_empty, out_o.key_code);
        mismatches++;
      end else begin
        oldest_pop = expected_pops.pop_front();
        if (out_o.buffer_empty !== oldest_pop.buffer_empty) begin
          $error("buffer_empty: expected %0d, got %0d",
                 oldest_pop.buffer_empty, out_o.buffer_empty);
          mismatches++;
        end
        if (out_o.key_code !== oldest_pop.key_code) begin
          $error("key_code: expected 0x%04h, got 0x%04h",
                 oldest_pop.key_code, out_o.key_code);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  function automatic kbsc_pkg::in_t byte_item(logic [7:0] b);
    return '{action: kbsc_pkg::ACT_BYTE, scan_byte: b};
  endfunction

  // the byte field of a read is ignored, so it carries noise
  function automatic kbsc_pkg::in_t read_item();
    return '{action: kbsc_pkg::ACT_READ, scan_byte: 8'($urandom)};
  endfunction

  // one in five bytes is a prefix, to get prefixed codes and prefix pairs
  function automatic logic [7:0] random_scan_byte();
    return ($urandom_range(0, 4) == 0) ? kbsc_pkg::PREFIX_BYTE : 8'($urandom);
  endfunction

  // one input transfer; valid stays high on return so that back-to-back
  // items never lower and raise it within one step
  task automatic send_item(kbsc_pkg::in_t item);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_key_code(item);
    items_sent++;
  endtask

  // sender holds off until every queued read result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pops.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // read straight out of reset finds nothing
  task automatic test_empty_read();
    send_item(read_item());
  endtask

  // unprefixed bytes come back as they went in; every byte bit toggles
  task automatic test_plain_bytes();
    send_item(byte_item(8'h00));
    send_item(byte_item(8'hFF));
    send_item(byte_item(8'h55));
    send_item(byte_item(8'hAA));
    repeat (4) send_item(read_item());
  endtask

  // prefix then byte gives 0xE0xx, including a prefix byte after a prefix
  task automatic test_prefixed_bytes();
    send_item(byte_item(kbsc_pkg::PREFIX_BYTE));
    send_item(byte_item(8'h00));
    send_item(byte_item(kbsc_pkg::PREFIX_BYTE));
    send_item(byte_item(8'hFF));
    send_item(byte_item(kbsc_pkg::PREFIX_BYTE));
    send_item(byte_item(kbsc_pkg::PREFIX_BYTE));
    repeat (3) send_item(read_item());
  endtask

  // a read between prefix and byte must not disturb the pending prefix
  task automatic test_read_during_prefix();
    send_item(byte_item(kbsc_pkg::PREFIX_BYTE));
    send_item(read_item());
    send_item(byte_item(8'h12));
    send_item(read_item());
  endtask

  // send capacity plus up to four random bytes, then drain into an empty read;
  // prefixed bytes that land on a full buffer are dropped too
  task automatic test_overflow_bursts(int unsigned rounds);
    repeat (rounds) begin
      repeat (FIFO_CAPACITY + $urandom_range(0, 4)) send_item(byte_item(random_scan_byte()));
      repeat (FIFO_DEPTH + 1) send_item(read_item());
    end
  endtask

  // mostly write bursts followed by read bursts, some raw noise in between
  task automatic test_random_traffic(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(0, 20)) send_item(byte_item(random_scan_byte()));
        repeat ($urandom_range(0, 20)) send_item(read_item());
      end else begin
        repeat (6) send_item(kbsc_pkg::in_t'(9'($urandom)));
      end
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back(int unsigned count);
    quiet = 1'b1;
    test_random_traffic(count);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_read();
    test_plain_bytes();
    test_prefixed_bytes();
    test_read_during_prefix();
    wait_for_results();

    test_random_traffic(600);
    wait_for_results();
    test_overflow_bursts(6);
    wait_for_results();
    test_back_to_back(200);

    // let the last result out, then give the block time to misbehave
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_pops.size() == 0) begin
      $display("keyboard_scancode_fifo regression: pass");
    end else begin
      $display("keyboard_scancode_fifo regression: fail");
    end
    $finish;
  end

endmodule
